// File: hdl/npc_pkg.sv
// Shared types and constants for the nearest palette color search core.
// Depends on nothing; every other file of the block imports it.
package npc_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [8:0] DEPTH_CNT = 9'(PALETTE_DEPTH);

    localparam int ROOT_W = 12;
    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 1;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_MATCH = 1'b1;

    localparam logic CFG_COUNT = 1'b0;
    localparam logic CFG_FORMAT = 1'b1;

    localparam logic [ROOT_W-1:0] DIST_NONE = '1;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [7:0]       idx;
        logic [11:0]      word;
    } entry_t;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [7:0]        idx;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } root_step_t;

endpackage

// File: hdl/nearest_palette_color_search_core.sv
// Top level of the nearest palette color search core: palette memory, search
// sequencer, distance front end, square root cell chain and best-match
// register. Uses npc_pkg, npc_dist and npc_root_cell.
//
// Usage: each input transfer carries tuser = func. With func 0 the entry word
// is written to the palette slot in the accepting cycle and no result follows.
// With func 1 the pixel is compared with palette entries 0 to count-1 (count
// held at 256 at most); one result transfer follows with the first entry of
// least distance. One entry leaves the palette memory per cycle into a
// pipeline of one read stage, three distance stages and twelve square root
// cells, one per result bit. A count of zero goes straight to the result
// without reading the palette.
// No new input is taken while a search runs. The result sits in an output
// register; palette writes are still taken while it waits, but a finished
// search holds until the register is free. Reset clears control state and sets
// count to 16 and format to 0; palette contents are undefined until written.
module nearest_palette_color_search_core
    import npc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_index[7:0], entry_word[19:8], red[27:20], green[35:28],
    // blue[43:36], zero [47:44]
    input  logic [47:0] s_tdata,
    // func[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // best_index[7:0], best_distance[19:8], zero [23:20]
    output logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [8:0] count_reg;
    logic       format_reg;
    logic [8:0] issue_reg;
    logic [8:0] issue_next;
    logic [8:0] limit_reg;
    logic [7:0] pix_r_reg;
    logic [7:0] pix_g_reg;
    logic [7:0] pix_b_reg;
    logic [7:0] best_idx_reg;
    logic [ROOT_W-1:0] best_dist_reg;
    logic        out_valid_reg;
    logic [7:0]  out_idx_reg;
    logic [ROOT_W-1:0] out_dist_reg;

    logic [11:0] palette_mem [PALETTE_DEPTH];
    logic        rd_valid_reg;
    logic        rd_last_reg;
    logic [7:0]  rd_idx_reg;
    logic [11:0] rd_word_reg;
    entry_t      rd_entry;
    logic        in_xfer;
    logic        issue;
    logic        out_free;
    logic [8:0]  count_sat;
    root_step_t  chain [ROOT_W+1];

    assign in_xfer   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || m_tready;
    assign issue     = (state_reg == ST_RUN) && (issue_reg != limit_reg);
    assign count_sat = (count_reg > DEPTH_CNT) ? DEPTH_CNT : count_reg;
    assign issue_next = issue_reg + 9'd1;
    assign rd_entry  = {rd_valid_reg, rd_last_reg, rd_idx_reg, rd_word_reg};

    always_ff @(posedge clk)
    begin
        if (in_xfer && s_tuser == FUNC_WRITE && {1'b0, s_tdata[7:0]} < DEPTH_CNT)
        begin
            palette_mem[s_tdata[ADDR_W-1:0]] <= s_tdata[19:8];
        end
        rd_word_reg <= palette_mem[issue_reg[ADDR_W-1:0]];
        rd_idx_reg  <= issue_reg[7:0];
        rd_last_reg <= (issue_next == limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 9'd16;
            format_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COUNT:  count_reg  <= cfg_data;
                CFG_FORMAT: format_reg <= cfg_data[0];
                default:    count_reg  <= count_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && s_tuser == FUNC_MATCH)
                begin
                    state_next = (count_sat == 9'd0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (issue_next == limit_reg)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (chain[ROOT_W].valid && chain[ROOT_W].last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                issue_reg <= '0;
            end
            else if (issue)
            begin
                issue_reg <= issue_next;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            limit_reg     <= count_sat;
            pix_r_reg     <= s_tdata[27:20];
            pix_g_reg     <= s_tdata[35:28];
            pix_b_reg     <= s_tdata[43:36];
            best_idx_reg  <= '0;
            best_dist_reg <= DIST_NONE;
        end
        else if (chain[ROOT_W].valid && chain[ROOT_W].root < best_dist_reg)
        begin
            best_idx_reg  <= chain[ROOT_W].idx;
            best_dist_reg <= chain[ROOT_W].root;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_idx_reg  <= best_idx_reg;
            out_dist_reg <= best_dist_reg;
        end
    end

    npc_dist u_dist
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .format   (format_reg),
        .pix_r    (pix_r_reg),
        .pix_g    (pix_g_reg),
        .pix_b    (pix_b_reg),
        .entry    (rd_entry),
        .radicand (chain[0])
    );

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_root
        npc_root_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .step_in  (chain[k]),
            .step_out (chain[k+1])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_dist_reg, out_idx_reg};

endmodule

// File: hdl/npc_dist.sv
// Three-stage weighted RGB distance front end: unpacks a palette word and
// forms the 32-bit wrapped weighted sum, shifted right by eight. Uses npc_pkg.
module npc_dist
    import npc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       format,
    input  logic [7:0] pix_r,
    input  logic [7:0] pix_g,
    input  logic [7:0] pix_b,
    input  entry_t     entry,
    output root_step_t radicand
);

    logic [8:0] q_r;
    logic [8:0] q_g;
    logic [8:0] q_b;
    logic signed [9:0] d_r;
    logic signed [9:0] d_g;
    logic signed [9:0] d_b;

    logic       s1_valid_reg;
    logic       s1_last_reg;
    logic [7:0] s1_idx_reg;
    logic [17:0] r2_reg;
    logic [17:0] g2_reg;
    logic [17:0] b2_reg;
    logic [8:0]  t_reg;

    logic       s2_valid_reg;
    logic       s2_last_reg;
    logic [7:0] s2_idx_reg;
    logic [21:0] base_reg;
    logic signed [28:0] prod_reg;
    logic signed [18:0] diff;
    logic [31:0] sum;

    logic       s3_valid_reg;
    logic       s3_last_reg;
    logic [7:0] s3_idx_reg;
    logic [RAD_W-1:0] rad_reg;

    always_comb
    begin
        if (format == 1'b0)
        begin
            q_r = {entry.word[11:8], 5'b0};
            q_g = {entry.word[7:4], 5'b0};
            q_b = {entry.word[3:0], 5'b0};
        end
        else
        begin
            q_r = {1'b0, entry.word[10:8], entry.word[11], 4'b0};
            q_g = {1'b0, entry.word[6:4], entry.word[7], 4'b0};
            q_b = {1'b0, entry.word[2:0], entry.word[3], 4'b0};
        end
        d_r = signed'({2'b0, pix_r}) - signed'({1'b0, q_r});
        d_g = signed'({2'b0, pix_g}) - signed'({1'b0, q_g});
        d_b = signed'({2'b0, pix_b}) - signed'({1'b0, q_b});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= entry.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign diff = signed'({1'b0, r2_reg}) - signed'({1'b0, b2_reg});
    assign sum  = 32'(base_reg) + 32'(prod_reg);

    always_ff @(posedge clk)
    begin
        s1_last_reg <= entry.last;
        s1_idx_reg  <= entry.idx;
        r2_reg      <= 18'(unsigned'(20'(d_r) * 20'(d_r)));
        g2_reg      <= 18'(unsigned'(20'(d_g) * 20'(d_g)));
        b2_reg      <= 18'(unsigned'(20'(d_b) * 20'(d_b)));
        t_reg       <= 9'(({2'b0, pix_r} + {1'b0, q_r}) >> 1);

        s2_last_reg <= s1_last_reg;
        s2_idx_reg  <= s1_idx_reg;
        base_reg    <= (22'(r2_reg) << 1) + (22'(g2_reg) << 2) + 22'(b2_reg) * 22'd3;
        prod_reg    <= 29'(signed'({1'b0, t_reg})) * 29'(diff);

        s3_last_reg <= s2_last_reg;
        s3_idx_reg  <= s2_idx_reg;
        rad_reg     <= sum[31:8];
    end

    assign radicand.valid = s3_valid_reg;
    assign radicand.last  = s3_last_reg;
    assign radicand.idx   = s3_idx_reg;
    assign radicand.rad   = rad_reg;
    assign radicand.rem   = '0;
    assign radicand.root  = '0;

endmodule

// File: hdl/npc_root_cell.sv
// One cell of the square root chain: settles one result bit per cycle and
// hands the shifted radicand, remainder and partial root on. Uses npc_pkg.
module npc_root_cell
    import npc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  root_step_t step_in,
    output root_step_t step_out
);

    logic [REM_W+1:0] acc;
    logic [REM_W+1:0] trial;
    logic             take;
    root_step_t       out_reg;

    assign acc   = {step_in.rem, step_in.rad[RAD_W-1 -: 2]};
    assign trial = (REM_W+2)'({step_in.root, 2'b01});
    assign take  = (acc >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else
        begin
            out_reg.valid <= step_in.valid;
            out_reg.last  <= step_in.last;
            out_reg.idx   <= step_in.idx;
            out_reg.rad   <= step_in.rad << 2;
            if (take)
            begin
                out_reg.rem  <= REM_W'(acc - trial);
                out_reg.root <= {step_in.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                out_reg.rem  <= REM_W'(acc);
                out_reg.root <= {step_in.root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign step_out = out_reg;

endmodule
